// ===== hw/rtl/timed_block_list_assert.svh =====
// Assertion macros used by the timed_block_list module.
`ifndef TIMED_BLOCK_LIST_ASSERT_SVH
`define TIMED_BLOCK_LIST_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define TBL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define TBL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define TBL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TBL_ASSERT(lbl, prop, msg)
`define TBL_ASSERT_IMPL(lbl, ante, cons, msg)
`define TBL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/tbl_pkg.sv =====
package tbl_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 16;
    localparam int ADDR_W              = 32;
    localparam int TS_W                = 32;
    localparam int TIMEOUT_W           = 31;
    localparam int OCC_W               = 5;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COMPACT,
        ST_FINISH
    } tbl_state_t;

    typedef struct packed {
        logic append;
        logic eval;
        logic compact;
    } tbl_cell_ctrl_t;

endpackage

// ===== hw/rtl/timed_block_list.sv =====
// Channel  Handshake                 Payload
// in       in_valid / in_ready       operation, ip_address, time_now
// out      out_valid / out_ready     banned, added, occupancy
// cfg      cfg_valid / cfg_ready     timeout_ticks
//
// An add writes the entry into its cell at the input transfer.
// A query evaluates every entry, then compacts: surviving entries slide down the cell
// chain, one slot per cycle, by up to MAX_ENTRIES - 1 slots.
// One item is in work at a time; the next input transfer may happen while a result waits.
// Reset empties the list at once; cfg_ready is always high.
`include "timed_block_list_assert.svh"

module timed_block_list
    import tbl_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  logic [ADDR_W-1:0]    ip_address,
    input  logic [TS_W-1:0]      time_now,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 banned,
    output logic                 added,
    output logic [OCC_W-1:0]     occupancy,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TIMEOUT_W-1:0] timeout_ticks
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    tbl_state_t           state_reg, state_next;
    tbl_cell_ctrl_t       ctrl;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        count_enc;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    q_addr_reg;
    logic [TS_W-1:0]      q_now_reg;
    logic                 added_reg, banned_reg;
    logic                 banned_out_reg, added_out_reg;
    logic [OCC_W-1:0]     occ_out_reg;
    logic                 in_xfer, full, done, out_free;

    logic [ADDR_W-1:0]    addr_vec [MAX_ENTRIES];
    logic [TS_W-1:0]      ts_vec   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] live_vec, match_vec;
    logic [MAX_ENTRIES:0]   live_ext;

    assign in_xfer  = in_valid && in_ready;
    assign full     = (count_reg == CW'(MAX_ENTRIES));
    assign out_free = !out_valid_reg || out_ready;
    assign live_ext = {1'b0, live_vec};

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            logic [ADDR_W-1:0] up_addr;
            logic [TS_W-1:0]   up_ts;
            logic              up_live, down_live;

            if (g == MAX_ENTRIES - 1)
            begin : g_top
                assign up_addr = '0;
                assign up_ts   = '0;
                assign up_live = 1'b0;
            end
            else
            begin : g_mid
                assign up_addr = addr_vec[g+1];
                assign up_ts   = ts_vec[g+1];
                assign up_live = live_vec[g+1];
            end

            if (g == 0)
            begin : g_bottom
                assign down_live = 1'b1;
            end
            else
            begin : g_rest
                assign down_live = live_vec[g-1];
            end

            tbl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sel        (count_reg == CW'(g)),
                .in_list    (CW'(g) < count_reg),
                .wr_addr    (ip_address),
                .wr_ts      (time_now),
                .q_addr     (q_addr_reg),
                .q_now      (q_now_reg),
                .timeout    (timeout_reg),
                .up_addr    (up_addr),
                .up_ts      (up_ts),
                .up_live    (up_live),
                .down_live  (down_live),
                .entry_addr (addr_vec[g]),
                .entry_ts   (ts_vec[g]),
                .live       (live_vec[g]),
                .match      (match_vec[g])
            );
        end
    endgenerate

    // Compaction is finished when no free slot sits directly below a live entry.
    always_comb
    begin
        done = 1'b1;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (!live_ext[i] && live_ext[i+1])
                done = 1'b0;
        end
    end

    // Once compacted, the live entries form a prefix; its top edge gives the count.
    always_comb
    begin
        count_enc = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (live_ext[i] && !live_ext[i+1])
                count_enc = count_enc | CW'(i + 1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = (operation == OP_ADD) ? ST_FINISH : ST_EVAL;
            end
            ST_EVAL:
                state_next = ST_COMPACT;
            ST_COMPACT:
            begin
                if (done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        ctrl         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.append = in_valid && (operation == OP_ADD);
            end
            ST_EVAL:
                ctrl.eval = 1'b1;
            ST_COMPACT:
                ctrl.compact = !done;
            ST_FINISH:
                in_ready = 1'b0;
            default:
                in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.append && !full)
            count_next = count_reg + 1'b1;
        else if (state_reg == ST_COMPACT && done)
            count_next = count_enc;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_FINISH && out_free)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            timeout_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                timeout_reg <= timeout_ticks;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            q_addr_reg <= ip_address;
            q_now_reg  <= time_now;
            added_reg  <= (operation == OP_ADD) && !full;
            banned_reg <= 1'b0;
        end
        if (state_reg == ST_COMPACT && done)
            banned_reg <= |match_vec;
        if (state_reg == ST_FINISH && out_free)
        begin
            banned_out_reg <= banned_reg;
            added_out_reg  <= added_reg;
            occ_out_reg    <= OCC_W'(count_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign banned    = banned_out_reg;
    assign added     = added_out_reg;
    assign occupancy = occ_out_reg;

    `TBL_ASSERT(a_count_bound, count_reg <= CW'(MAX_ENTRIES),
        "entry count above capacity")
    `TBL_ASSERT_NEXT(a_compact_keeps_entries, state_reg == ST_COMPACT,
        $countones(live_vec) == $past($countones(live_vec)),
        "compaction changed the number of live entries")
    `TBL_ASSERT_IMPL(a_added_nonempty, state_reg == ST_FINISH && added_reg,
        count_reg != '0, "stored add left the list empty")
    `TBL_ASSERT_IMPL(a_result_exclusive, out_valid_reg,
        !(banned_out_reg && added_out_reg), "result flags banned and added both set")

endmodule

// ===== hw/rtl/tbl_cell.sv =====
module tbl_cell
    import tbl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbl_cell_ctrl_t       ctrl,
    input  logic                 sel,
    input  logic                 in_list,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [TS_W-1:0]      wr_ts,
    input  logic [ADDR_W-1:0]    q_addr,
    input  logic [TS_W-1:0]      q_now,
    input  logic [TIMEOUT_W-1:0] timeout,
    input  logic [ADDR_W-1:0]    up_addr,
    input  logic [TS_W-1:0]      up_ts,
    input  logic                 up_live,
    input  logic                 down_live,
    output logic [ADDR_W-1:0]    entry_addr,
    output logic [TS_W-1:0]      entry_ts,
    output logic                 live,
    output logic                 match
);

    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic              live_reg, live_next;
    logic              match_reg, match_next;
    logic [TS_W-1:0]   age;
    logic              keep;

    assign age  = q_now - ts_reg;
    assign keep = in_list && (age < {1'b0, timeout});

    always_comb
    begin
        addr_next  = addr_reg;
        ts_next    = ts_reg;
        live_next  = live_reg;
        match_next = match_reg;
        if (ctrl.append && sel)
        begin
            addr_next = wr_addr;
            ts_next   = wr_ts;
        end
        if (ctrl.eval)
        begin
            live_next  = keep;
            match_next = keep && (addr_reg == q_addr);
        end
        if (ctrl.compact)
        begin
            if (!live_reg && up_live)
            begin
                // The entry above slides down into this free slot.
                addr_next = up_addr;
                ts_next   = up_ts;
                live_next = 1'b1;
            end
            else if (live_reg && !down_live)
            begin
                live_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            live_reg  <= live_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        ts_reg   <= ts_next;
    end

    assign entry_addr = addr_reg;
    assign entry_ts   = ts_reg;
    assign live       = live_reg;
    assign match      = match_reg;

endmodule

// ===== bench/tb_timed_block_list.sv =====
module tb_timed_block_list
    import tbl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = DEFAULT_MAX_ENTRIES;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = {TIMEOUT_W{1'b1}};

    typedef struct packed {
        logic            op;
        logic [ADDR_W-1:0] ip;
        logic [TS_W-1:0]   stamp;
    } request_t;

    typedef struct packed {
        logic             banned;
        logic             added;
        logic [OCC_W-1:0] occupancy;
    } verdict_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 operation = OP_ADD;
    logic [ADDR_W-1:0]    ip_address = '0;
    logic [TS_W-1:0]      time_now = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 banned;
    logic                 added;
    logic [OCC_W-1:0]     occupancy;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TIMEOUT_W-1:0] timeout_ticks = '0;

    request_t request_q[$];
    verdict_t verdict_q[$];

    logic [ADDR_W-1:0]    list_ip [LIST_DEPTH];
    logic [TS_W-1:0]      list_stamp [LIST_DEPTH];
    int                   list_len = 0;
    logic [TIMEOUT_W-1:0] model_timeout = '0;

    bit in_taken = 1'b0;
    bit cfg_taken = 1'b0;
    bit bench_idle = 1'b1;
    bit in_steady = 1'b0;
    bit out_steady = 1'b0;
    int send_hold = 0;
    int stall_left = 0;
    int cycle_count = 0;
    int err_count = 0;

    timed_block_list dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .ip_address   (ip_address),
        .time_now     (time_now),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .banned       (banned),
        .added        (added),
        .occupancy    (occupancy),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .timeout_ticks(timeout_ticks)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // An add appends at the tail unless the list is full; a query first drops every
    // entry whose wrapped age has reached the timeout, keeping the rest in order.
    function automatic verdict_t blocklist_apply(request_t req);
        verdict_t v;
        int keep;
        int i;
        logic [TS_W-1:0] age;
        v = '0;
        if (req.op == OP_ADD)
        begin
            if (list_len < LIST_DEPTH)
            begin
                list_ip[list_len] = req.ip;
                list_stamp[list_len] = req.stamp;
                list_len++;
                v.added = 1'b1;
            end
        end
        else
        begin
            keep = 0;
            for (i = 0; i < list_len; i++)
            begin
                age = req.stamp - list_stamp[i];
                if (age < TS_W'(model_timeout))
                begin
                    list_ip[keep] = list_ip[i];
                    list_stamp[keep] = list_stamp[i];
                    keep++;
                end
            end
            list_len = keep;
            for (i = 0; i < list_len; i++)
                if (list_ip[i] == req.ip)
                    v.banned = 1'b1;
        end
        v.occupancy = OCC_W'(list_len);
        return v;
    endfunction

    always @(posedge clk)
    begin
        verdict_t want;
        request_t req;
        in_taken = in_valid && in_ready;
        cfg_taken = cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_taken)
                model_timeout = timeout_ticks;
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result transfer with no result expected");
                    err_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (banned !== want.banned)
                    begin
                        $error("banned: expected %0d, actual %0d", want.banned, banned);
                        err_count++;
                    end
                    if (added !== want.added)
                    begin
                        $error("added: expected %0d, actual %0d", want.added, added);
                        err_count++;
                    end
                    if (occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, actual %0d",
                               want.occupancy, occupancy);
                        err_count++;
                    end
                end
            end
            if (in_taken)
            begin
                req.op = operation;
                req.ip = ip_address;
                req.stamp = time_now;
                verdict_q.push_back(blocklist_apply(req));
            end
            cycle_count++;
            if (cycle_count % 128 == 0)
            begin
                in_steady = ($urandom_range(0, 3) == 0);
                out_steady = ($urandom_range(0, 3) == 0);
            end
        end
        bench_idle = (request_q.size() == 0) && !(in_valid && !in_taken)
                     && (verdict_q.size() == 0);
    end

    always @(negedge clk)
    begin
        request_t nxt;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_hold > 0)
            begin
                in_valid <= 1'b0;
                send_hold--;
            end
            else if (request_q.size() != 0)
            begin
                nxt = request_q.pop_front();
                in_valid <= 1'b1;
                operation <= nxt.op;
                ip_address <= nxt.ip;
                time_now <= nxt.stamp;
                send_hold = in_steady ? 0 : draw_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!out_steady && $urandom_range(0, 3) == 0)
                    stall_left = draw_gap();
            end
        end
    end

    task automatic push_req(input logic op, input logic [ADDR_W-1:0] ip,
                            input logic [TS_W-1:0] stamp);
        request_t r;
        r.op = op;
        r.ip = ip;
        r.stamp = stamp;
        request_q.push_back(r);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (!bench_idle);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        timeout_ticks <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [ADDR_W-1:0]    pool [6];
        logic [ADDR_W-1:0]    ip;
        logic [TS_W-1:0]      tick;
        logic [TS_W-1:0]      stamp;
        logic [31:0]          step_cap;
        logic [TIMEOUT_W-1:0] limit_val;
        logic                 op;
        int ph;
        int n;
        int k;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With the timeout still at zero, a query empties the whole list.
        push_req(OP_ADD, 32'h0000_0000, 32'h0000_0000);
        push_req(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(OP_QUERY, 32'h0000_0000, 32'h0000_0000);
        drain();

        write_timeout(TIMEOUT_W'(10));
        for (k = 0; k < LIST_DEPTH; k++)
        begin
            case (k)
                0: ip = 32'h0000_0000;
                1, 2: ip = 32'hFFFF_FFFF;
                default: ip = 32'hA5A5_0000 | k;
            endcase
            push_req(OP_ADD, ip, 100 + k);
        end
        push_req(OP_ADD, 32'h1234_5678, 116);
        push_req(OP_QUERY, 32'hFFFF_FFFF, 110);
        push_req(OP_QUERY, 32'hA5A5_0009, 119);
        push_req(OP_QUERY, 32'h0000_0000, 119);
        drain();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: limit_val = TIMEOUT_MAX;
                1: limit_val = TIMEOUT_W'(1);
                2: limit_val = TIMEOUT_W'(0);
                3: limit_val = TIMEOUT_W'($urandom_range(8, 64));
                4: limit_val = TIMEOUT_W'($urandom_range(100, 2000));
                5: limit_val = TIMEOUT_W'($urandom);
                6: limit_val = TIMEOUT_W'($urandom_range(2, 16));
                default: limit_val = TIMEOUT_W'($urandom_range(30, 300));
            endcase
            write_timeout(limit_val);
            step_cap = 32'(limit_val >> 2);
            if (step_cap > 32'h0040_0000)
                step_cap = 32'h0040_0000;
            if (step_cap < 3)
                step_cap = 3;
            for (k = 0; k < 6; k++)
                pool[k] = $urandom;
            tick = $urandom;
            for (n = 0; n < 225; n++)
            begin
                if (ph == 4 && n == 110)
                    drain();
                tick += $urandom_range(0, step_cap);
                op = $urandom_range(0, 1) ? OP_QUERY : OP_ADD;
                ip = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, 5)];
                stamp = ($urandom_range(0, 19) == 0) ? $urandom : tick;
                push_req(op, ip, stamp);
            end
            drain();
        end

        repeat (48) @(posedge clk);
        if (err_count == 0)
            $display("** timed_block_list: PASSED **");
        else
            $display("** timed_block_list: FAILED **");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("** timed_block_list: FAILED **");
        $finish;
    end

endmodule
